@@ rtl/bitmap_block_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared property wrappers used by the allocator's checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Constants, codes and search helpers for the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int ROWS    = 1 << ROW_W;
  localparam int WORD_W  = 1 << COL_W;
  localparam logic [CNT_W-1:0] MAX_BLOCKS = CNT_W'(ROWS * WORD_W);

  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_MARK  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // {found, position} of the lowest clear bit in a byte
  function automatic logic [3:0] first_zero8(input logic [7:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) r = {1'b1, 3'(i)};
    end
    return r;
  endfunction

  // {found, position} of the lowest clear bit in a 64-bit word
  function automatic logic [6:0] first_zero64(input logic [63:0] w);
    logic [3:0] z [8];
    logic [7:0] byte_full;
    logic [3:0] g;
    for (int b = 0; b < 8; b++) begin
      z[b] = first_zero8(w[b*8 +: 8]);
      byte_full[b] = !z[b][3];
    end
    g = first_zero8(byte_full);
    return {g[3], g[2:0], z[g[2:0]][2:0]};
  endfunction

endpackage

@@ rtl/bitmap_block_allocator.sv @@
// An accepted command reads its 64-bit map row into a register, waits in S_RD
// and does the read-modify-write in S_EX; done strobes as the state returns to
// idle. busy is high in S_RD and S_EX, so no command is accepted until done.
// Reset clears the map at once through per-row valid bits, sets the total to
// 4096 and the free count to 4096; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a 4096-bit used map held as 64 rows of 64 bits,
// with a per-row full summary that picks the row to search.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       action,
  input  logic [IDX_W-1:0] block_index,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             done,
  output logic [IDX_W-1:0] result_block,
  output logic             bit_value,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] free_count
);

`include "bitmap_block_allocator_defines.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  total_blocks;
  logic [CNT_W-1:0]  free_blocks;
  logic [CNT_W-1:0]  free_blocks_next;
  logic [ROWS-1:0]   row_vld;
  logic [ROWS-1:0]   row_full;

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rd_data;

  logic [2:0]        action_q;
  logic [IDX_W-1:0]  index_q;
  logic [ROW_W-1:0]  row_q;
  logic              row_vld_q;
  logic              nonfull_q;

  logic              accept;
  logic [6:0]        row_pick;
  logic [ROW_W-1:0]  rd_row;
  logic [CNT_W-1:0]  eff_total;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] word_new;
  logic [WORD_W-1:0] col_mask;
  logic [6:0]        col_pick;
  logic [IDX_W-1:0]  cand;
  logic              in_range;
  logic              alloc_ok;
  logic              do_write;
  logic [ROW_W-1:0]  wr_row;
  logic [IDX_W-1:0]  res_block_next;
  logic              bit_next;
  logic [1:0]        status_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign eff_total = (total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : total_blocks;

  // lowest row with a clear bit
  assign row_pick = first_zero64(row_full);
  assign rd_row   = (action == ACT_ALLOC) ? row_pick[ROW_W-1:0]
                                          : block_index[IDX_W-1 -: ROW_W];

  always_ff @(posedge clk) begin
    if (do_write) mem[wr_row] <= word_new;
    if (accept) rd_data <= mem[rd_row];
  end

  // execute stage: one row read-modify-write
  always_comb begin
    word     = row_vld_q ? rd_data : '0;
    col_pick = first_zero64(word);
    cand     = {row_q, col_pick[COL_W-1:0]};
    in_range = ({1'b0, index_q} < eff_total);
    alloc_ok = (free_blocks != '0) && nonfull_q && col_pick[COL_W] &&
               ({1'b0, cand} < eff_total);
    col_mask = '0;
    word_new = word;
    do_write = 1'b0;
    wr_row   = row_q;
    free_blocks_next = free_blocks;
    res_block_next   = '0;
    bit_next         = 1'b0;
    status_next      = ST_OK;
    case (action_q)
      ACT_INIT: begin
        free_blocks_next = eff_total;
      end
      ACT_ALLOC: begin
        col_mask[col_pick[COL_W-1:0]] = 1'b1;
        if (alloc_ok) begin
          word_new         = word | col_mask;
          do_write         = 1'b1;
          free_blocks_next = free_blocks - CNT_W'(1);
          res_block_next   = cand;
          bit_next         = 1'b1;
        end else begin
          status_next = ST_NOFREE;
        end
      end
      ACT_FREE, ACT_MARK, ACT_READ: begin
        col_mask[index_q[COL_W-1:0]] = 1'b1;
        res_block_next = index_q;
        if (!in_range) begin
          status_next = ST_RANGE;
        end else if (action_q == ACT_FREE) begin
          word_new = word & ~col_mask;
          do_write = 1'b1;
          free_blocks_next = (free_blocks >= eff_total) ? eff_total
                                                        : free_blocks + CNT_W'(1);
        end else if (action_q == ACT_MARK) begin
          word_new = word | col_mask;
          do_write = 1'b1;
          if (free_blocks != '0) free_blocks_next = free_blocks - CNT_W'(1);
          bit_next = 1'b1;
        end else begin
          bit_next = word[index_q[COL_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    if (state != S_EX) do_write = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q  <= action;
      index_q   <= block_index;
      row_q     <= rd_row;
      row_vld_q <= row_vld[rd_row];
      nonfull_q <= row_pick[ROW_W];
    end
    if (state == S_EX) begin
      result_block <= res_block_next;
      bit_value    <= bit_next;
      status       <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_blocks <= MAX_BLOCKS;
      free_blocks  <= MAX_BLOCKS;
      row_vld      <= '0;
      row_full     <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) total_blocks <= cfg_data;
      case (state)
        S_IDLE: begin
          if (accept) state <= S_RD;
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          free_blocks <= free_blocks_next;
          if (action_q == ACT_INIT) begin
            row_vld  <= '0;
            row_full <= '0;
          end else if (do_write) begin
            row_vld[wr_row]  <= 1'b1;
            row_full[wr_row] <= &word_new;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign free_count = free_blocks;

  `BBA_ASSERT_NEXT(a_accept_busy, accept, busy)
  `BBA_ASSERT_NOW(a_done_idle, done, state == S_IDLE)
  `BBA_ASSERT_NOW(a_nofree_zero, done && status == ST_NOFREE,
                  result_block == '0 && !bit_value)
  `BBA_ASSERT_NOW(a_alloc_used, done && action_q == ACT_ALLOC && status == ST_OK,
                  bit_value)

endmodule

@@ tb/sv/bitmap_block_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives init, allocate, free, mark_used and read_bit commands through the
// start/busy port and checks every done beat against an in-bench model of
// the used map and free count. A directed table hits the reset state, the
// field extremes and the error paths. Random phases then run several totals,
// including 0, 1, 4096 and 8191, with random sender gaps except in the last 4096 and the 8191 phase.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test
  import bba_pkg::*;
();

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic [IDX_W-1:0] blk;
    logic             bitv;
    logic [1:0]       st;
    logic [CNT_W-1:0] cnt;
  } alloc_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [2:0]       act;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cfg_val;
    logic             known;
    alloc_result_t    res;
  } dir_row_t;

  logic             clk;
  logic             rst         = 1'b1;
  logic             start       = 1'b0;
  logic             busy;
  logic [2:0]       action      = ACT_INIT;
  logic [IDX_W-1:0] block_index = '0;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data    = '0;
  logic             done;
  logic [IDX_W-1:0] result_block;
  logic             bit_value;
  logic [1:0]       status;
  logic [CNT_W-1:0] free_count;

  // model state
  bit               used_bits [MAX_BLOCKS];
  int               free_cnt;
  logic [CNT_W-1:0] total_reg;

  alloc_result_t    pending_results [$];
  dir_row_t         directed_rows [$];
  logic             fail_flag = 1'b0;
  logic             gaps_on   = 1'b1;

  bitmap_block_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .block_index  (block_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .result_block (result_block),
    .bit_value    (bit_value),
    .status       (status),
    .free_count   (free_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int managed_blocks();
    return (int'(total_reg) > int'(MAX_BLOCKS)) ? int'(MAX_BLOCKS) : int'(total_reg);
  endfunction

  function automatic alloc_result_t predict_action(input logic [2:0] act,
                                                   input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int lim;
    int hit;
    lim = managed_blocks();
    r = '0;
    case (act)
      ACT_INIT: begin
        foreach (used_bits[i]) used_bits[i] = 1'b0;
        free_cnt = lim;
      end
      ACT_ALLOC: begin
        hit = -1;
        if (free_cnt != 0) begin
          for (int i = 0; i < lim; i++) begin
            if (!used_bits[i]) begin
              hit = i;
              break;
            end
          end
        end
        if (hit >= 0) begin
          used_bits[hit] = 1'b1;
          free_cnt--;
          r.blk = IDX_W'(hit);
          r.bitv = 1'b1;
        end else begin
          r.st = ST_NOFREE;
        end
      end
      ACT_FREE, ACT_MARK, ACT_READ: begin
        r.blk = idx;
        if (int'(idx) >= lim) begin
          r.st = ST_RANGE;
        end else if (act == ACT_FREE) begin
          used_bits[idx] = 1'b0;
          free_cnt = (free_cnt >= lim) ? lim : free_cnt + 1;
        end else if (act == ACT_MARK) begin
          used_bits[idx] = 1'b1;
          if (free_cnt != 0) free_cnt--;
          r.bitv = 1'b1;
        end else begin
          r.bitv = used_bits[idx];
        end
      end
      default: ;
    endcase
    r.cnt = CNT_W'(free_cnt);
    return r;
  endfunction

  function automatic dir_row_t cmd_row(input logic [2:0] act, input logic [IDX_W-1:0] idx);
    dir_row_t row;
    row.kind = ROW_CMD;
    row.act = act;
    row.idx = idx;
    row.cfg_val = '0;
    row.known = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] blk, input logic bitv,
                                         input logic [1:0] st, input logic [CNT_W-1:0] cnt);
    dir_row_t row;
    row = cmd_row(act, idx);
    row.known = 1'b1;
    row.res = '{blk: blk, bitv: bitv, st: st, cnt: cnt};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CNT_W-1:0] val);
    dir_row_t row;
    row = cmd_row(ACT_INIT, '0);
    row.kind = ROW_CFG;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int lim;
    int span;
    int roll;
    lim = managed_blocks();
    roll = $urandom_range(99);
    if (lim == 0 || roll < 12) return IDX_W'($urandom);
    if (roll < 20) return IDX_W'(lim - 1 + $urandom_range(0, 1));
    span = (lim < 128) ? lim : 128;
    if (roll < 65) return IDX_W'($urandom_range(0, span - 1));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [2:0] pick_action();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) return ACT_INIT;
    if (roll < 4) return 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if (roll < 42) return ACT_ALLOC;
    if (roll < 67) return ACT_FREE;
    if (roll < 77) return ACT_MARK;
    return ACT_READ;
  endfunction

  // start is left high after a beat so a back-to-back command does not toggle it
  task automatic send_cmd(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                          input logic known, input alloc_result_t known_res);
    alloc_result_t predicted;
    if (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    block_index <= idx;
    do @(posedge clk); while (busy);
    predicted = predict_action(act, idx);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  // start is already low when nothing is pending
  task automatic wait_drained();
    if (pending_results.size() != 0) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] val);
    wait_drained();
    if (gaps_on && $urandom_range(99) < 50) repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= CNT_W'($urandom);
    total_reg = val;
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: result_block %0d status %0d", result_block, status);
        fail_flag = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (result_block !== want.blk) begin
          $error("result_block: expected %0d, got %0d", want.blk, result_block);
          fail_flag = 1'b1;
        end
        if (bit_value !== want.bitv) begin
          $error("bit_value: expected %0d, got %0d", want.bitv, bit_value);
          fail_flag = 1'b1;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fail_flag = 1'b1;
        end
        if (free_count !== want.cnt) begin
          $error("free_count: expected %0d, got %0d", want.cnt, free_count);
          fail_flag = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("bitmap_block_allocator_test failed");
    $finish;
  end

  initial begin : stimulus
    int phase_totals [12];
    int tot;
    dir_row_t row;
    logic [2:0] act;

    foreach (used_bits[i]) used_bits[i] = 1'b0;
    total_reg = CNT_W'(4096);
    free_cnt = managed_blocks();

    directed_rows.push_back(known_row(ACT_READ, 12'd0, 12'd0, 1'b0, ST_OK, 13'd4096));
    directed_rows.push_back(known_row(ACT_READ, 12'd4095, 12'd4095, 1'b0, ST_OK, 13'd4096));
    directed_rows.push_back(known_row(ACT_ALLOC, 12'd0, 12'd0, 1'b1, ST_OK, 13'd4095));
    directed_rows.push_back(known_row(ACT_ALLOC, 12'd4095, 12'd1, 1'b1, ST_OK, 13'd4094));
    directed_rows.push_back(cmd_row(ACT_FREE, 12'd0));
    directed_rows.push_back(cmd_row(ACT_FREE, 12'd0));    // already free, count still rises
    directed_rows.push_back(cmd_row(ACT_MARK, 12'd4095));
    directed_rows.push_back(cmd_row(ACT_MARK, 12'd4095)); // already used
    directed_rows.push_back(cmd_row(ACT_SPARE_LO, 12'd4095));
    directed_rows.push_back(cmd_row(ACT_SPARE_HI, 12'd0));
    directed_rows.push_back(cmd_row(ACT_INIT, 12'd4095));
    directed_rows.push_back(cfg_row(13'd1));
    directed_rows.push_back(known_row(ACT_FREE, 12'd1, 12'd1, 1'b0, ST_RANGE, 13'd4096));
    directed_rows.push_back(cmd_row(ACT_ALLOC, 12'd0));
    // count nonzero but nothing free below the total
    directed_rows.push_back(known_row(ACT_ALLOC, 12'd0, 12'd0, 1'b0, ST_NOFREE, 13'd4095));
    directed_rows.push_back(cmd_row(ACT_FREE, 12'd0));    // count above total drops to it
    directed_rows.push_back(cmd_row(ACT_INIT, 12'd0));
    directed_rows.push_back(cmd_row(ACT_MARK, 12'd0));
    directed_rows.push_back(cmd_row(ACT_MARK, 12'd0));    // count stays at zero
    directed_rows.push_back(known_row(ACT_ALLOC, 12'd0, 12'd0, 1'b0, ST_NOFREE, 13'd0));
    directed_rows.push_back(cfg_row(13'd0));
    directed_rows.push_back(cmd_row(ACT_INIT, 12'd0));
    directed_rows.push_back(known_row(ACT_READ, 12'd0, 12'd0, 1'b0, ST_RANGE, 13'd0));
    directed_rows.push_back(cmd_row(ACT_ALLOC, 12'd0));
    directed_rows.push_back(cfg_row(13'd8191));
    directed_rows.push_back(cmd_row(ACT_INIT, 12'd0));
    directed_rows.push_back(cmd_row(ACT_ALLOC, 12'd0));
    directed_rows.push_back(cmd_row(ACT_READ, 12'd4095));

    phase_totals = '{4096, 1, 8, 64, 65, 0, 4096, 8191, 2, -1, 17, -1};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) write_total(row.cfg_val);
      else send_cmd(row.act, row.idx, row.known, row.res);
    end

    foreach (phase_totals[p]) begin
      tot = (phase_totals[p] < 0) ? $urandom_range(1, 4096) : phase_totals[p];
      gaps_on = !(p == 6 || p == 7);
      write_total(CNT_W'(tot));
      if ($urandom_range(9) != 0) send_cmd(ACT_INIT, pick_index(), 1'b0, '0);
      repeat (PHASE_ITEMS) begin
        act = pick_action();
        send_cmd(act, pick_index(), 1'b0, '0);
        if ($urandom_range(99) == 0) wait_drained();
      end
    end

    write_total(CNT_W'(4096));
    send_cmd(ACT_INIT, pick_index(), 1'b0, '0);
    wait_drained();
    repeat (8) @(posedge clk);

    if (!fail_flag && pending_results.size() == 0)
      $display("bitmap_block_allocator_test passed");
    else
      $display("bitmap_block_allocator_test failed");
    $finish;
  end

endmodule
